/* rtl/core/vspag_pkg.sv */
package vspag_pkg;

    // dimension limits and field widths
    localparam int unsigned MAX_WIDTH  = 8192;
    localparam int unsigned MAX_HEIGHT = 8192;
    localparam int unsigned DIM_W      = 14;
    localparam int unsigned PITCH_W    = 16;
    localparam int unsigned STEP_W     = 17;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned SLICE_W    = 8;
    localparam int unsigned PADDR_W    = 5;

    // register indexes
    localparam logic [2:0] REG_FORMAT = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_PITCH  = 3'd3;
    localparam logic [2:0] REG_UP     = 3'd4;
    localparam logic [2:0] REG_SLICES = 3'd5;
    localparam logic [2:0] REG_BASE   = 3'd6;

    // pixel format codes
    localparam logic [5:0] FMT_RGBA     = 6'd0;
    localparam logic [5:0] FMT_RGB32    = 6'd1;
    localparam logic [5:0] FMT_RGB24    = 6'd2;
    localparam logic [5:0] FMT_RGB565   = 6'd3;
    localparam logic [5:0] FMT_RGB555   = 6'd4;
    localparam logic [5:0] FMT_ARGB1555 = 6'd5;
    localparam logic [5:0] FMT_RGB8     = 6'd6;
    localparam logic [5:0] FMT_RGB4     = 6'd7;
    localparam logic [5:0] FMT_RGB1     = 6'd8;
    localparam logic [5:0] FMT_YUY2     = 6'd9;
    localparam logic [5:0] FMT_UYVY     = 6'd10;
    localparam logic [5:0] FMT_YVYU     = 6'd11;
    localparam logic [5:0] FMT_VYUY     = 6'd12;
    localparam logic [5:0] FMT_I420     = 6'd13;
    localparam logic [5:0] FMT_YV12     = 6'd14;
    localparam logic [5:0] FMT_YVU9     = 6'd15;
    localparam logic [5:0] FMT_YUV9     = 6'd16;
    localparam logic [5:0] FMT_IYU1     = 6'd17;
    localparam logic [5:0] FMT_IYU2     = 6'd18;
    localparam logic [5:0] FMT_Y41P     = 6'd19;
    localparam logic [5:0] FMT_CLJR     = 6'd20;
    localparam logic [5:0] FMT_Y800     = 6'd21;
    localparam logic [5:0] FMT_Y16      = 6'd22;
    localparam logic [5:0] FMT_AYUV     = 6'd23;
    localparam logic [5:0] FMT_IMC1     = 6'd24;
    localparam logic [5:0] FMT_IMC2     = 6'd25;
    localparam logic [5:0] FMT_IMC3     = 6'd26;
    localparam logic [5:0] FMT_IMC4     = 6'd27;
    localparam logic [5:0] FMT_NV12     = 6'd28;
    localparam logic [5:0] FMT_NV21     = 6'd29;
    localparam logic [5:0] FMT_Y42T     = 6'd30;
    localparam logic [5:0] FMT_Y41T     = 6'd31;
    localparam logic [5:0] FMT_YV16     = 6'd32;

    // component byte orders y0 | y1<<2 | u<<4 | v<<6
    localparam logic [7:0] ORD_YUY2 = 8'hD8;
    localparam logic [7:0] ORD_UYVY = 8'h8D;
    localparam logic [7:0] ORD_YVYU = 8'h78;
    localparam logic [7:0] ORD_VYUY = 8'h2D;
    localparam logic [7:0] ORD_NV12 = 8'h40;
    localparam logic [7:0] ORD_NV21 = 8'h10;

    // plane arrangement classes
    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_SINGLE = 3'd1,
        K_PLANAR = 3'd2,
        K_IMC    = 3'd3,
        K_NV     = 3'd4,
        K_YV16   = 3'd5
    } t_kind;

    // frame description derived from the registers
    typedef struct packed {
        t_kind                kind;
        logic                 up;
        logic                 ufirst;
        logic [1:0]           cshift;
        logic [DIM_W-1:0]     h;
        logic [DIM_W-1:0]     uvh;
        logic [SLICE_W-1:0]   s;
        logic [PITCH_W-1:0]   ys;
        logic [PITCH_W-1:0]   cs;
        logic [DIM_W-1:0]     cw;
        logic [7:0]           order;
        logic [2:0]           tail;
        logic [ADDR_W-1:0]    base;
        logic [ADDR_W-1:0]    first;
        logic [ADDR_W-1:0]    second;
    } t_frame;

endpackage

/* rtl/core/vspag_cfg.sv */
module vspag_cfg
    import vspag_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output t_frame              o_frame
);

    logic [5:0]          r_format;
    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;
    logic [PITCH_W-1:0]  r_pitch;
    logic                r_up;
    logic [SLICE_W-1:0]  r_slices;
    logic [ADDR_W-1:0]   r_base;

    // first derived layer
    t_kind               r_kind, n_kind;
    logic                r_ufirst, n_ufirst;
    logic [1:0]          r_cshift, n_cshift;
    logic [DIM_W-1:0]    r_w, n_w;
    logic [DIM_W-1:0]    r_h, n_h;
    logic [DIM_W-1:0]    r_uvh, n_uvh;
    logic [SLICE_W-1:0]  r_s, n_s;
    logic [PITCH_W-1:0]  r_ys, n_ys;
    logic [PITCH_W-1:0]  r_cs, n_cs;
    logic [DIM_W-1:0]    r_cw, n_cw;
    logic [7:0]          r_order, n_order;
    logic [2:0]          r_tail, n_tail;
    logic [DIM_W:0]      r_h1, n_h1;
    logic [PITCH_W-1:0]  r_x2, n_x2;
    logic [DIM_W:0]      r_y2, n_y2;
    logic                r_sec_base, n_sec_base;
    // plane base products and sums
    logic [30:0]         r_m1;
    logic [31:0]         r_m2;
    logic [ADDR_W-1:0]   r_first;
    logic [ADDR_W-1:0]   r_second;
    logic                r_sec_base2;

    logic                wr_en;
    logic [2:0]          reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= '0;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_pitch  <= '0;
            r_up     <= 1'b0;
            r_slices <= SLICE_W'(1);
            r_base   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FORMAT: r_format <= pwdata[5:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_PITCH:  r_pitch  <= pwdata[PITCH_W-1:0];
                REG_UP:     r_up     <= pwdata[0];
                REG_SLICES: r_slices <= pwdata[SLICE_W-1:0];
                REG_BASE:   r_base   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_FORMAT: prdata = 32'(r_format);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_PITCH:  prdata = 32'(r_pitch);
            REG_UP:     prdata = 32'(r_up);
            REG_SLICES: prdata = 32'(r_slices);
            REG_BASE:   prdata = r_base;
            default:    prdata = '0;
        endcase
    end

    // format decode: pitches, chroma geometry and plane layout
    always_comb begin
        logic [PITCH_W-1:0] minp;
        logic [PITCH_W-1:0] wp;
        logic [PITCH_W-1:0] pmax;
        logic [DIM_W-1:0]   uvw;
        logic [DIM_W:0]     al;
        logic [DIM_W:0]     al2;
        logic               small_req;
        logic [16:0]        w12;
        n_w = (r_width == '0) ? DIM_W'(1) :
              ((32'(r_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : r_width);
        n_h = (r_height == '0) ? DIM_W'(1) :
              ((32'(r_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : r_height);
        n_s = (r_slices == '0) ? SLICE_W'(1) : r_slices;
        wp = PITCH_W'(n_w);
        w12 = 17'(n_w) * 17'd12;
        pmax = (r_pitch < wp) ? wp : r_pitch;
        small_req = (r_pitch <= wp);
        minp = '0;
        n_kind = K_SINGLE;
        n_ufirst = 1'b0;
        n_cshift = 2'd0;
        n_cw = '0;
        n_order = '0;
        n_tail = '0;
        n_ys = '0;
        n_cs = '0;
        n_h1 = (DIM_W+1)'(n_h);
        n_x2 = '0;
        n_y2 = '0;
        n_sec_base = 1'b0;
        uvw = '0;
        al = ((DIM_W+1)'(n_h) + (DIM_W+1)'(15)) & ~(DIM_W+1)'(15);
        al2 = '0;
        case (r_format)
            FMT_RGBA, FMT_RGB32, FMT_AYUV: minp = wp << 2;
            FMT_RGB24, FMT_IYU2: minp = PITCH_W'(wp * PITCH_W'(3));
            FMT_RGB565, FMT_RGB555, FMT_ARGB1555, FMT_Y16, FMT_Y42T: minp = wp << 1;
            FMT_RGB8, FMT_CLJR, FMT_Y800: minp = wp;
            FMT_RGB4: begin
                minp = (wp + PITCH_W'(1)) >> 1;
                n_tail = 3'(n_w[0]);
            end
            FMT_RGB1: begin
                minp = (wp + PITCH_W'(7)) >> 3;
                n_tail = n_w[2:0];
            end
            FMT_YUY2: begin minp = wp << 1; n_order = ORD_YUY2; end
            FMT_UYVY: begin minp = wp << 1; n_order = ORD_UYVY; end
            FMT_YVYU: begin minp = wp << 1; n_order = ORD_YVYU; end
            FMT_VYUY: begin minp = wp << 1; n_order = ORD_VYUY; end
            FMT_IYU1: minp = PITCH_W'(w12 >> 3);
            FMT_Y41P, FMT_Y41T: minp = PITCH_W'((wp >> 3) * PITCH_W'(12));
            FMT_I420, FMT_YV12, FMT_YVU9, FMT_YUV9: begin
                n_kind = K_PLANAR;
                n_ufirst = (r_format == FMT_I420) || (r_format == FMT_YUV9);
                n_cshift = (r_format <= FMT_YV12) ? 2'd1 : 2'd2;
                uvw = n_w >> n_cshift;
                n_cw = uvw;
                n_ys = small_req ? wp : r_pitch;
                n_cs = small_req ? PITCH_W'(uvw) : r_pitch;
                n_x2 = n_cs;
                n_y2 = (DIM_W+1)'(n_h >> n_cshift);
            end
            FMT_IMC1, FMT_IMC2, FMT_IMC3, FMT_IMC4: begin
                n_kind = K_IMC;
                n_ufirst = (r_format >= FMT_IMC3);
                n_cshift = 2'd1;
                uvw = n_w >> 1;
                n_cw = uvw;
                n_ys = pmax;
                n_cs = pmax;
                if ((r_format == FMT_IMC2) || (r_format == FMT_IMC4)) begin
                    n_x2 = PITCH_W'(uvw);
                    n_y2 = (DIM_W+1)'(1);
                end else begin
                    al2 = (al + (DIM_W+1)'(n_h >> 1) + (DIM_W+1)'(15)) & ~(DIM_W+1)'(15);
                    n_h1 = al;
                    n_x2 = pmax;
                    n_y2 = al2;
                    n_sec_base = 1'b1;
                end
            end
            FMT_NV12, FMT_NV21: begin
                n_kind = K_NV;
                n_ufirst = 1'b1;
                n_cshift = 2'd1;
                n_cw = n_w;
                n_ys = pmax;
                n_cs = pmax;
                n_order = (r_format == FMT_NV12) ? ORD_NV12 : ORD_NV21;
            end
            FMT_YV16: begin
                n_kind = K_YV16;
                uvw = n_w >> 1;
                n_cw = uvw;
                n_ys = small_req ? wp : r_pitch;
                n_cs = small_req ? PITCH_W'(uvw) : r_pitch;
                n_x2 = n_cs;
                n_y2 = (DIM_W+1)'(n_h);
            end
            default: n_kind = K_NONE;
        endcase
        if (n_kind == K_SINGLE) begin
            n_ys = (r_pitch < minp) ? minp : r_pitch;
        end
        n_uvh = n_h >> n_cshift;
    end

    // derived values are registered behind the registers: decoded fields first,
    // then plane base products, then the first plane base and then the second
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_ufirst    <= n_ufirst;
        r_cshift    <= n_cshift;
        r_w         <= n_w;
        r_h         <= n_h;
        r_uvh       <= n_uvh;
        r_s         <= n_s;
        r_ys        <= n_ys;
        r_cs        <= n_cs;
        r_cw        <= n_cw;
        r_order     <= n_order;
        r_tail      <= n_tail;
        r_h1        <= n_h1;
        r_x2        <= n_x2;
        r_y2        <= n_y2;
        r_sec_base  <= n_sec_base;
        r_m1        <= 31'(r_ys) * 31'(r_h1);
        r_m2        <= 32'(r_x2) * 32'(r_y2);
        r_sec_base2 <= r_sec_base;
        r_first     <= r_base + 32'(r_m1);
        r_second    <= (r_sec_base2 ? r_base : r_first) + r_m2;
    end

    always_comb begin
        o_frame.kind   = r_kind;
        o_frame.up     = r_up;
        o_frame.ufirst = r_ufirst;
        o_frame.cshift = r_cshift;
        o_frame.h      = r_h;
        o_frame.uvh    = r_uvh;
        o_frame.s      = r_s;
        o_frame.ys     = r_ys;
        o_frame.cs     = r_cs;
        o_frame.cw     = (r_w == '0) ? '0 : r_cw;
        o_frame.order  = r_order;
        o_frame.tail   = r_tail;
        o_frame.base   = r_base;
        o_frame.first  = r_first;
        o_frame.second = r_second;
    end

endmodule

/* rtl/core/video_slice_plane_address_gen.sv */
// Slice address generator for a frame buffer: each request on the slave stream
// carries a slice number and yields one descriptor on the master stream with
// the slice's row count, luma and chroma start addresses, signed row steps,
// chroma geometry, component byte order and tail pixels. One request is taken
// per clock unless the pipeline is backed up from the master side; a descriptor
// passes a capture stage, a 14-stage restoring divider for height / slice count
// and four multiply and add stages. Stalls on the master side fill any empty
// stages before backing up to the input. The user must write registers over the
// APB port only while no request is in flight; the block does not enforce this.
// The frame description derived from them is built in registered layers.
module video_slice_plane_address_gen
    import vspag_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [7:0] slice_number
    input  logic [7:0]          i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [13:0] slice_rows, [45:14] luma_start, [62:46] luma_step,
    // [94:63] u_start, [126:95] v_start, [143:127] chroma_step,
    // [157:144] chroma_width, [171:158] chroma_slice_rows,
    // [179:172] component_order, [182:180] tail_pixels, [183] zero
    output logic [183:0]        o_m_axis_tdata
);

    localparam int unsigned DIV_N = DIM_W;
    localparam int unsigned E1    = DIV_N + 1;
    localparam int unsigned E2    = DIV_N + 2;
    localparam int unsigned E3    = DIV_N + 3;
    localparam int unsigned E4    = DIV_N + 4;
    localparam int unsigned NST   = DIV_N + 5;

    t_frame frm;

    vspag_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_frame (frm)
    );

    logic [NST-1:0]      r_v;
    logic [NST:0]        rdy;

    logic [SLICE_W-1:0]  r_n   [0:DIV_N];
    logic [SLICE_W-1:0]  r_rem [0:DIV_N];
    logic [DIM_W-1:0]    r_q   [0:DIV_N];

    logic [DIM_W-1:0]    r1_sr, r2_sr, r3_sr;
    logic [21:0]         r1_nsr, r1_nuv;
    logic [ADDR_W-1:0]   r2_tl, r2_tc;
    logic [ADDR_W-1:0]   r3_lo, r3_co;
    logic [183:0]        r4_data, n4_data;

    // stage moves when empty or when the stage after it moves
    always_comb begin
        rdy[NST] = i_m_axis_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_s_axis_tready = rdy[0];
    assign o_m_axis_tvalid = r_v[NST-1];
    assign o_m_axis_tdata  = r4_data;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_n[0]   <= i_s_axis_tdata;
            r_rem[0] <= '0;
            r_q[0]   <= '0;
        end
    end

    // restoring divider, one quotient bit a stage: rows = height / slices
    always_ff @(posedge i_clk) begin
        for (int d = 1; d <= DIV_N; d++) begin
            logic [SLICE_W:0] trial;
            logic             ge;
            trial = {r_rem[d-1], frm.h[DIV_N-d]};
            ge = (trial >= {1'b0, frm.s});
            if (rdy[d]) begin
                r_n[d]   <= r_n[d-1];
                r_rem[d] <= ge ? SLICE_W'(trial - {1'b0, frm.s}) : SLICE_W'(trial);
                r_q[d]   <= {r_q[d-1][DIM_W-2:0], ge};
            end
        end
    end

    // slice row offsets
    always_ff @(posedge i_clk) begin
        if (rdy[E1]) begin
            r1_sr  <= r_q[DIV_N];
            r1_nsr <= 22'(r_n[DIV_N]) * 22'(r_q[DIV_N]);
            r1_nuv <= 22'(r_n[DIV_N]) * 22'(r_q[DIV_N] >> frm.cshift);
        end
    end

    // row index from top or from bottom, wrapping at 32 bits
    always_ff @(posedge i_clk) begin
        if (rdy[E2]) begin
            r2_sr <= r1_sr;
            r2_tl <= frm.up ? (32'(frm.h) - 32'd1 - 32'(r1_nsr)) : 32'(r1_nsr);
            r2_tc <= frm.up ? (32'(frm.uvh) - 32'd1 - 32'(r1_nuv)) : 32'(r1_nuv);
        end
    end

    // byte offsets
    always_ff @(posedge i_clk) begin
        if (rdy[E3]) begin
            r3_sr <= r2_sr;
            r3_lo <= 32'(48'(frm.ys) * 48'(r2_tl));
            r3_co <= 32'(48'(frm.cs) * 48'(r2_tc));
        end
    end

    // descriptor assembly
    always_comb begin
        logic [ADDR_W-1:0] luma;
        logic [ADDR_W-1:0] us;
        logic [ADDR_W-1:0] vs;
        logic [STEP_W-1:0] lstep;
        logic [STEP_W-1:0] cstep;
        logic [DIM_W-1:0]  crows;
        logic [DIM_W-1:0]  cw;
        luma  = frm.base + r3_lo;
        lstep = frm.up ? (STEP_W'(0) - STEP_W'(frm.ys)) : STEP_W'(frm.ys);
        cstep = frm.up ? (STEP_W'(0) - STEP_W'(frm.cs)) : STEP_W'(frm.cs);
        crows = r3_sr >> frm.cshift;
        cw    = frm.cw;
        us    = frm.ufirst ? (frm.first + r3_co) : (frm.second + r3_co);
        vs    = frm.ufirst ? (frm.second + r3_co) : (frm.first + r3_co);
        case (frm.kind)
            K_NONE: begin
                n4_data = '0;
            end
            K_SINGLE: begin
                n4_data = {1'b0, frm.tail, frm.order, DIM_W'(0), DIM_W'(0),
                           STEP_W'(0), ADDR_W'(0), ADDR_W'(0), lstep, luma, r3_sr};
            end
            K_NV: begin
                n4_data = {1'b0, frm.tail, frm.order, crows, cw,
                           cstep, ADDR_W'(0), us, lstep, luma, r3_sr};
            end
            default: begin
                n4_data = {1'b0, frm.tail, frm.order, crows, cw,
                           cstep, vs, us, lstep, luma, r3_sr};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[E4]) begin
            r4_data <= n4_data;
        end
    end

    // checks
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && frm.kind == K_NONE) |-> (o_m_axis_tdata == '0))
        else $error("unknown format gave a non-zero descriptor");

    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[13:0] <= frm.h))
        else $error("slice rows exceed frame height");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> o_s_axis_tready)
        else $error("empty input stage refused a request");

    a_free_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("pipeline stalled with the output free");

    a_step_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !frm.up) |-> !o_m_axis_tdata[62])
        else $error("negative luma step for a top-down frame");

endmodule

/* bench/tb.sv */
module tb;
    import vspag_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one slice descriptor as it leaves the block
    typedef struct packed {
        logic [2:0]  tail;
        logic [7:0]  order;
        logic [13:0] crows;
        logic [13:0] cw;
        logic [16:0] cstep;
        logic [31:0] vs;
        logic [31:0] us;
        logic [16:0] lstep;
        logic [31:0] luma;
        logic [13:0] rows;
    } t_slice_desc;

    // frame registers as the bench believes them
    typedef struct {
        logic [5:0]  fmt;
        logic [13:0] w;
        logic [13:0] h;
        logic [15:0] pitch;
        logic        up;
        logic [7:0]  s;
        logic [31:0] base;
    } t_frame_regs;

    int errors = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    // slice descriptor predictor and store of descriptors still to come
    class slice_scoreboard;
        t_frame_regs regs;
        t_slice_desc pending[$];

        function longint unsigned row_addr(longint unsigned plane, longint unsigned p,
                                           longint unsigned rows, longint unsigned n,
                                           longint unsigned sr, bit up);
            if (up) return plane + p * ((rows - 1) - n * sr);
            return plane + n * sr * p;
        endfunction

        function logic [16:0] step_of(longint unsigned p, bit up);
            longint unsigned v;
            v = up ? (64'd0 - p) : p;
            return v[16:0];
        endfunction

        function longint unsigned a16(longint unsigned x);
            return (x + 15) & ~64'd15;
        endfunction

        function t_slice_desc predict(logic [7:0] num);
            t_slice_desc d;
            longint unsigned w, h, s, sr, n, minp, p, ys, cs, uvw, uvh, uvsr, off, fst, snd, dv;
            longint unsigned luma, us, vs, tail, order, cw, crows;
            logic [16:0] ls, cst;
            bit up, single, ok, ufirst, inter;
            n = num;
            w = regs.w == 0 ? 1 : (regs.w > MAX_WIDTH ? MAX_WIDTH : regs.w);
            h = regs.h == 0 ? 1 : (regs.h > MAX_HEIGHT ? MAX_HEIGHT : regs.h);
            s = regs.s == 0 ? 1 : regs.s;
            sr = h / s;
            up = regs.up;
            luma = 0; us = 0; vs = 0; tail = 0; order = 0; cw = 0; crows = 0;
            ls = 0; cst = 0; minp = 0; single = 0; ok = 1;
            case (regs.fmt)
                FMT_RGBA, FMT_RGB32, FMT_AYUV: begin minp = w * 4; single = 1; end
                FMT_RGB24, FMT_IYU2: begin minp = w * 3; single = 1; end
                FMT_RGB565, FMT_RGB555, FMT_ARGB1555, FMT_Y16, FMT_Y42T: begin
                    minp = w * 2; single = 1;
                end
                FMT_RGB8, FMT_CLJR, FMT_Y800: begin minp = w; single = 1; end
                FMT_RGB4: begin minp = (w + 1) / 2; tail = w % 2; single = 1; end
                FMT_RGB1: begin minp = (w + 7) / 8; tail = w % 8; single = 1; end
                FMT_YUY2: begin minp = w * 2; order = ORD_YUY2; single = 1; end
                FMT_UYVY: begin minp = w * 2; order = ORD_UYVY; single = 1; end
                FMT_YVYU: begin minp = w * 2; order = ORD_YVYU; single = 1; end
                FMT_VYUY: begin minp = w * 2; order = ORD_VYUY; single = 1; end
                FMT_IYU1: begin minp = w * 12 / 8; single = 1; end
                FMT_Y41P, FMT_Y41T: begin minp = w / 8 * 12; single = 1; end
                FMT_I420, FMT_YV12, FMT_YVU9, FMT_YUV9: begin
                    ufirst = regs.fmt == FMT_I420 || regs.fmt == FMT_YUV9;
                    dv = regs.fmt <= FMT_YV12 ? 2 : 4;
                    uvw = w / dv; uvh = h / dv; uvsr = uvh / s;
                    if (regs.pitch <= w) begin ys = w; cs = uvw; end
                    else begin ys = regs.pitch; cs = regs.pitch; end
                    luma = row_addr(regs.base, ys, h, n, sr, up);
                    off = row_addr(0, cs, uvh, n, uvsr, up);
                    fst = regs.base + ys * h;
                    snd = fst + cs * uvh;
                    if (ufirst) begin us = fst + off; vs = snd + off; end
                    else begin vs = fst + off; us = snd + off; end
                    ls = step_of(ys, up); cst = step_of(cs, up);
                    cw = uvw; crows = uvsr;
                end
                FMT_IMC1, FMT_IMC2, FMT_IMC3, FMT_IMC4: begin
                    ufirst = regs.fmt >= FMT_IMC3;
                    inter = regs.fmt == FMT_IMC2 || regs.fmt == FMT_IMC4;
                    p = regs.pitch < w ? w : regs.pitch;
                    uvw = w / 2; uvh = h / 2; uvsr = uvh / s;
                    luma = row_addr(regs.base, p, h, n, sr, up);
                    off = row_addr(0, p, uvh, n, uvsr, up);
                    if (inter) begin
                        fst = regs.base + p * h; snd = fst + uvw;
                    end else begin
                        fst = regs.base + a16(h) * p;
                        snd = regs.base + a16(a16(h) + uvh) * p;
                    end
                    if (ufirst) begin us = fst + off; vs = snd + off; end
                    else begin vs = fst + off; us = snd + off; end
                    ls = step_of(p, up); cst = ls;
                    cw = uvw; crows = uvsr;
                end
                FMT_NV12, FMT_NV21: begin
                    p = regs.pitch < w ? w : regs.pitch;
                    uvh = h / 2; uvsr = uvh / s;
                    luma = row_addr(regs.base, p, h, n, sr, up);
                    us = row_addr(regs.base + p * h, p, uvh, n, uvsr, up);
                    ls = step_of(p, up); cst = ls;
                    cw = w; crows = uvsr;
                    order = regs.fmt == FMT_NV12 ? ORD_NV12 : ORD_NV21;
                end
                FMT_YV16: begin
                    uvw = w / 2;
                    if (regs.pitch <= w) begin ys = w; cs = uvw; end
                    else begin ys = regs.pitch; cs = regs.pitch; end
                    luma = row_addr(regs.base, ys, h, n, sr, up);
                    off = row_addr(0, cs, h, n, sr, up);
                    fst = regs.base + ys * h;
                    vs = fst + off;
                    us = fst + cs * h + off;
                    ls = step_of(ys, up); cst = step_of(cs, up);
                    cw = uvw; crows = sr;
                end
                default: ok = 0;
            endcase
            if (single) begin
                p = regs.pitch < minp ? minp : regs.pitch;
                if (p > 65535) p = 65535;
                luma = row_addr(regs.base, p, h, n, sr, up);
                ls = step_of(p, up);
            end
            d = '0;
            if (ok) begin
                d.rows = sr[13:0]; d.luma = luma[31:0]; d.lstep = ls;
                d.us = us[31:0]; d.vs = vs[31:0]; d.cstep = cst;
                d.cw = cw[13:0]; d.crows = crows[13:0];
                d.order = order[7:0]; d.tail = tail[2:0];
            end
            return d;
        endfunction

        function void note_request(logic [7:0] num);
            pending.push_back(predict(num));
        endfunction

        task check_desc(logic [183:0] data);
            t_slice_desc g, e;
            g = data[182:0];
            if (data[183] !== 1'b0) report("pad bit", data[183], 0);
            if (pending.size() == 0) begin
                report("unexpected descriptor", g.luma, 0);
                return;
            end
            e = pending.pop_front();
            if (g.rows !== e.rows) report("slice_rows", g.rows, e.rows);
            if (g.luma !== e.luma) report("luma_start", g.luma, e.luma);
            if (g.lstep !== e.lstep) report("luma_step", g.lstep, e.lstep);
            if (g.us !== e.us) report("u_start", g.us, e.us);
            if (g.vs !== e.vs) report("v_start", g.vs, e.vs);
            if (g.cstep !== e.cstep) report("chroma_step", g.cstep, e.cstep);
            if (g.cw !== e.cw) report("chroma_width", g.cw, e.cw);
            if (g.crows !== e.crows) report("chroma_slice_rows", g.crows, e.crows);
            if (g.order !== e.order) report("component_order", g.order, e.order);
            if (g.tail !== e.tail) report("tail_pixels", g.tail, e.tail);
        endtask
    endclass

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic i_s_axis_tvalid, o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;
    logic o_m_axis_tvalid, i_m_axis_tready;
    logic [183:0] o_m_axis_tdata;

    video_slice_plane_address_gen u_dut (.*);

    slice_scoreboard sb;
    int  idle_pct = 24;
    bit  hold_off = 0;
    bit  stim_done = 0;
    longint cycles = 0;

    // clock
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // result side: random back-pressure, long hold-off on demand
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_desc(o_m_axis_tdata);
        if (hold_off) i_m_axis_tready <= 1'b0;
        else i_m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= PADDR_W'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_FORMAT: sb.regs.fmt = val[5:0];
            REG_WIDTH:  sb.regs.w = val[13:0];
            REG_HEIGHT: sb.regs.h = val[13:0];
            REG_PITCH:  sb.regs.pitch = val[15:0];
            REG_UP:     sb.regs.up = val[0];
            REG_SLICES: sb.regs.s = val[7:0];
            REG_BASE:   sb.regs.base = val;
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [5:0] f, input logic [13:0] w, input logic [13:0] h,
                             input logic [15:0] p, input logic u, input logic [7:0] s,
                             input logic [31:0] b);
        reg_write(REG_FORMAT, 32'(f));
        reg_write(REG_WIDTH, 32'(w));
        reg_write(REG_HEIGHT, 32'(h));
        reg_write(REG_PITCH, 32'(p));
        reg_write(REG_UP, 32'(u));
        reg_write(REG_SLICES, 32'(s));
        reg_write(REG_BASE, b);
        repeat (4) @(posedge i_clk);
    endtask

    // one slice request, with random gaps before it
    task automatic send_slice(input logic [7:0] num);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata <= num;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_request(num);
    endtask

    task automatic drain;
        int guard;
        i_s_axis_tvalid <= 0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (30) @(posedge i_clk);
    endtask

    logic [13:0] rw, rh;
    int k;

    initial begin
        sb = new();
        sb.regs = '{fmt: 0, w: 1, h: 1, pitch: 0, up: 0, s: 1, base: 0};
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_s_axis_tvalid = 0; i_s_axis_tdata = '0; i_m_axis_tready = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset values, slice zero and the largest slice number
        send_slice(8'd0);
        send_slice(8'd255);
        drain();

        // every format once, alternating top and bottom row order, plus two unknown codes
        for (int f = 0; f <= 34; f++) begin
            set_frame(6'(f), 14'd1921, 14'd1081, 16'd0, f[0], 8'd4, 32'hFFFF_F000);
            send_slice(8'd0);
            send_slice(8'd3);
            drain();
        end

        // extremes: zero sizes, oversize sizes, zero slices, huge pitch, unknown code
        set_frame(FMT_RGB1, 14'd0, 14'd0, 16'd0, 1'b1, 8'd0, 32'h0);
        send_slice(8'd0); send_slice(8'd200);
        drain();
        set_frame(FMT_RGBA, 14'h3FFF, 14'h3FFF, 16'hFFFF, 1'b1, 8'd255, 32'hFFFF_FFFF);
        send_slice(8'd254); send_slice(8'd255);
        drain();
        set_frame(FMT_RGB4, 14'd8191, 14'd17, 16'd1, 1'b0, 8'd1, 32'h1234_5678);
        send_slice(8'hAA); send_slice(8'h55);
        drain();
        set_frame(6'h3F, 14'd100, 14'd100, 16'd200, 1'b1, 8'd3, 32'h8000_0000);
        send_slice(8'd1);
        drain();

        // random frames, several slices each
        for (int ph = 0; ph < 32; ph++) begin
            rw = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(1, 700));
            rh = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(1, 700));
            set_frame(6'($urandom_range(0, 35)), rw, rh,
                      ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 800)),
                      1'($urandom), 8'($urandom_range(0, 20)), $urandom);
            idle_pct = (ph >= 10 && ph < 15) ? 0 : 24;
            if (ph == 20) begin
                // receiver holds off for a long stretch while requests keep coming
                fork
                    begin
                        hold_off = 1;
                        repeat (200) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            // enough requests in the hold-off phase to fill the pipeline
            for (k = 0; k < ((ph == 20) ? 40 : 10); k++)
                send_slice(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)));
            drain();
        end
        idle_pct = 24;

        if (errors == 0 && sb.pending.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
